>>> design/first_fit_heap_allocator_core_macros.svh
// Assertion macros for the first-fit heap allocator core
`ifndef FIRST_FIT_HEAP_ALLOCATOR_CORE_MACROS_SVH
`define FIRST_FIT_HEAP_ALLOCATOR_CORE_MACROS_SVH

// same-cycle implication, disabled while in reset
`define FFHA_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("ffha assertion failed");

// next-cycle implication, disabled while in reset
`define FFHA_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("ffha assertion failed");

`endif

>>> design/ffha_pkg.sv
// Types, constants and helper functions for the first-fit heap allocator
`default_nettype none

package ffha_pkg;

    localparam int MAX_BLOCKS   = 64;
    localparam int IDX_W        = $clog2(MAX_BLOCKS);
    localparam int CNT_W        = $clog2(MAX_BLOCKS + 1);
    localparam int ADDR_W       = 22;
    localparam int SUM_W        = ADDR_W + 2;
    localparam int HEADER_BYTES = 8;
    localparam int HEAP_LIMIT   = 4063232;
    localparam int HEAP_GAP     = 4096;
    localparam int TAIL_PAD     = 4;
    localparam int IMAGE_END_RST = 1048576;

    localparam logic [ADDR_W-1:0] ADDR_MAX = {ADDR_W{1'b1}};

    localparam logic KIND_ALLOC = 1'b0;
    localparam logic KIND_FREE  = 1'b1;

    localparam logic [2:0] ST_OK         = 3'd0;
    localparam logic [2:0] ST_ZERO_SIZE  = 3'd1;
    localparam logic [2:0] ST_NO_MEM     = 3'd2;
    localparam logic [2:0] ST_TABLE_FULL = 3'd3;
    localparam logic [2:0] ST_NOT_FOUND  = 3'd4;

    typedef struct packed {
        logic              kind;
        logic [ADDR_W-1:0] size;
        logic [ADDR_W-1:0] address;
    } t_req;

    typedef struct packed {
        logic [ADDR_W-1:0] address_res;
        logic [2:0]        status;
        logic [ADDR_W-1:0] used_bytes;
    } t_res;

    // one block record as held in the record memory
    typedef struct packed {
        logic [ADDR_W-1:0] start;
        logic [ADDR_W-1:0] size;
        logic              in_use;
    } t_rec;

    localparam int REC_W = $bits(t_rec);

    // heap base for a given kernel end, clamped to the heap end
    function automatic logic [ADDR_W-1:0] heap_start(input logic [ADDR_W-1:0] kend);
        logic [ADDR_W:0] s;
        s = {1'b0, kend} + (ADDR_W + 1)'(HEAP_GAP);
        return (s > (ADDR_W + 1)'(HEAP_LIMIT)) ? ADDR_W'(HEAP_LIMIT) : s[ADDR_W-1:0];
    endfunction

    // saturating add onto the used count
    function automatic logic [ADDR_W-1:0] used_add(input logic [ADDR_W-1:0] used,
                                                   input logic [SUM_W-1:0]  n);
        logic [SUM_W-1:0] s;
        s = {2'b00, used} + n;
        return (s > {2'b00, ADDR_MAX}) ? ADDR_MAX : s[ADDR_W-1:0];
    endfunction

endpackage

`default_nettype wire

>>> design/ffha_ram.sv
// Generic single-write, single-read RAM with registered read data
`default_nettype none

module ffha_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic                     i_re,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            o_rdata <= r_mem[i_raddr];
        end
    end

endmodule

`default_nettype wire

>>> design/ffha_seq.sv
// Record walk sequencer: owns the record memory, block count, bump pointer and used count
`default_nettype none

module ffha_seq (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire logic                       i_start,
    input  var  ffha_pkg::t_req             i_req,
    input  wire logic                       i_init,
    input  wire logic [ffha_pkg::ADDR_W-1:0] i_heap_start,
    input  wire logic                       i_res_take,
    output logic                            o_idle,
    output logic                            o_res_valid,
    output ffha_pkg::t_res                  o_res
);

    typedef enum logic [3:0] {
        S_IDLE   = 4'b0001,
        S_WALK   = 4'b0010,
        S_APPEND = 4'b0100,
        S_RESP   = 4'b1000
    } t_state;

    t_state                          r_state, n_state;
    ffha_pkg::t_req                  r_req, n_req;
    ffha_pkg::t_res                  r_res, n_res;
    logic [ffha_pkg::CNT_W-1:0]      r_count, n_count;
    logic [ffha_pkg::ADDR_W-1:0]     r_bump, n_bump;
    logic [ffha_pkg::ADDR_W-1:0]     r_used, n_used;
    logic [ffha_pkg::CNT_W-1:0]      r_rd_idx, n_rd_idx;
    logic                            r_chk_vld, n_chk_vld;
    logic [ffha_pkg::IDX_W-1:0]      r_chk_idx, n_chk_idx;

    logic                            w_we, w_re;
    logic [ffha_pkg::IDX_W-1:0]      w_waddr;
    ffha_pkg::t_rec                  w_wdata, w_rec;
    logic [ffha_pkg::REC_W-1:0]      w_rdata;

    logic                            w_fit, w_match, w_hit;
    logic [ffha_pkg::ADDR_W-1:0]     w_used_reuse, w_used_free, w_used_app;
    logic [ffha_pkg::ADDR_W:0]       w_drop;
    logic [ffha_pkg::SUM_W-1:0]      w_end, w_next_bump;
    logic                            w_oom;

    ffha_ram #(
        .WIDTH (ffha_pkg::REC_W),
        .DEPTH (ffha_pkg::MAX_BLOCKS)
    ) u_rec_ram (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_waddr),
        .i_wdata (w_wdata),
        .i_re    (w_re),
        .i_raddr (r_rd_idx[ffha_pkg::IDX_W-1:0]),
        .o_rdata (w_rdata)
    );

    assign w_rec = ffha_pkg::t_rec'(w_rdata);

    // record check on the data read in the previous cycle
    assign w_fit   = !w_rec.in_use && (w_rec.size >= r_req.size);
    assign w_match = ({1'b0, w_rec.start} + (ffha_pkg::ADDR_W + 1)'(ffha_pkg::HEADER_BYTES))
                     == {1'b0, r_req.address};
    assign w_hit   = r_chk_vld && ((r_req.kind == ffha_pkg::KIND_ALLOC) ? w_fit : w_match);

    assign w_used_reuse = ffha_pkg::used_add(r_used,
        {2'b00, r_req.size} + ffha_pkg::SUM_W'(ffha_pkg::HEADER_BYTES));
    assign w_drop      = {1'b0, w_rec.size} + (ffha_pkg::ADDR_W + 1)'(ffha_pkg::HEADER_BYTES);
    assign w_used_free = (w_drop >= {1'b0, r_used}) ? '0 : (r_used - w_drop[ffha_pkg::ADDR_W-1:0]);

    assign w_end = {2'b00, r_bump} + {2'b00, r_req.size}
                 + ffha_pkg::SUM_W'(ffha_pkg::HEADER_BYTES);
    assign w_oom = w_end >= ffha_pkg::SUM_W'(ffha_pkg::HEAP_LIMIT);
    assign w_next_bump = w_end + ffha_pkg::SUM_W'(ffha_pkg::TAIL_PAD);
    assign w_used_app  = ffha_pkg::used_add(r_used, {2'b00, r_req.size}
        + ffha_pkg::SUM_W'(ffha_pkg::HEADER_BYTES + ffha_pkg::TAIL_PAD));

    assign o_idle      = (r_state == S_IDLE);
    assign o_res_valid = (r_state == S_RESP);
    assign o_res       = r_res;

    always_comb begin
        n_state   = r_state;
        n_req     = r_req;
        n_res     = r_res;
        n_count   = r_count;
        n_bump    = r_bump;
        n_used    = r_used;
        n_rd_idx  = r_rd_idx;
        n_chk_vld = r_chk_vld;
        n_chk_idx = r_chk_idx;
        w_we      = 1'b0;
        w_re      = 1'b0;
        w_waddr   = r_chk_idx;
        w_wdata   = w_rec;
        case (r_state)
            S_IDLE: begin
                if (i_init) begin
                    n_count = '0;
                    n_bump  = i_heap_start;
                    n_used  = '0;
                end
                if (i_start) begin
                    n_req = i_req;
                    if (i_req.kind == ffha_pkg::KIND_ALLOC && i_req.size == '0) begin
                        n_res   = '{address_res: '0, status: ffha_pkg::ST_ZERO_SIZE,
                                    used_bytes: r_used};
                        n_state = S_RESP;
                    end else begin
                        n_rd_idx  = '0;
                        n_chk_vld = 1'b0;
                        n_state   = S_WALK;
                    end
                end
            end
            S_WALK: begin
                n_chk_vld = 1'b0;
                if (w_hit) begin
                    w_we = 1'b1;
                    w_wdata.in_use = (r_req.kind == ffha_pkg::KIND_ALLOC);
                    if (r_req.kind == ffha_pkg::KIND_ALLOC) begin
                        n_used = w_used_reuse;
                        n_res  = '{address_res: w_rec.start
                                        + ffha_pkg::ADDR_W'(ffha_pkg::HEADER_BYTES),
                                   status: ffha_pkg::ST_OK, used_bytes: w_used_reuse};
                    end else begin
                        n_used = w_used_free;
                        n_res  = '{address_res: '0, status: ffha_pkg::ST_OK,
                                   used_bytes: w_used_free};
                    end
                    n_state = S_RESP;
                end else if (r_rd_idx < r_count) begin
                    // next record read overlaps the check of the current one
                    w_re      = 1'b1;
                    n_rd_idx  = r_rd_idx + ffha_pkg::CNT_W'(1);
                    n_chk_vld = 1'b1;
                    n_chk_idx = r_rd_idx[ffha_pkg::IDX_W-1:0];
                end else if (!r_chk_vld) begin
                    n_state = S_APPEND;
                end
            end
            S_APPEND: begin
                n_state = S_RESP;
                if (r_req.kind == ffha_pkg::KIND_FREE) begin
                    n_res = '{address_res: '0, status: ffha_pkg::ST_NOT_FOUND,
                              used_bytes: r_used};
                end else if (w_oom) begin
                    n_res = '{address_res: '0, status: ffha_pkg::ST_NO_MEM,
                              used_bytes: r_used};
                end else if (r_count >= ffha_pkg::CNT_W'(ffha_pkg::MAX_BLOCKS)) begin
                    n_res = '{address_res: '0, status: ffha_pkg::ST_TABLE_FULL,
                              used_bytes: r_used};
                end else begin
                    w_we    = 1'b1;
                    w_waddr = r_count[ffha_pkg::IDX_W-1:0];
                    w_wdata = '{start: r_bump, size: r_req.size, in_use: 1'b1};
                    n_count = r_count + ffha_pkg::CNT_W'(1);
                    n_bump  = (w_next_bump > {2'b00, ffha_pkg::ADDR_MAX}) ? ffha_pkg::ADDR_MAX
                                                   : w_next_bump[ffha_pkg::ADDR_W-1:0];
                    n_used  = w_used_app;
                    n_res   = '{address_res: r_bump + ffha_pkg::ADDR_W'(ffha_pkg::HEADER_BYTES),
                                status: ffha_pkg::ST_OK, used_bytes: w_used_app};
                end
            end
            S_RESP: begin
                if (i_res_take) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_count   <= '0;
            r_bump    <= ffha_pkg::heap_start(ffha_pkg::ADDR_W'(ffha_pkg::IMAGE_END_RST));
            r_used    <= '0;
            r_chk_vld <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_count   <= n_count;
            r_bump    <= n_bump;
            r_used    <= n_used;
            r_chk_vld <= n_chk_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r_req     <= n_req;
        r_res     <= n_res;
        r_rd_idx  <= n_rd_idx;
        r_chk_idx <= n_chk_idx;
    end

endmodule

`default_nettype wire

>>> design/first_fit_heap_allocator_core.sv
// Top level of the first-fit heap allocator: handshakes, configuration and result register
//
// First-fit heap allocator. Each request item allocates (kind 0) or frees (kind 1) one block;
// every item gives exactly one result item. Block records live in a 64-entry record memory
// walked one record per cycle, the read of the next record overlapping the check of the
// current one. An item's walk ends on the first matching record or after the last record,
// so a record that matches early ends it sooner; a zero-size allocate skips the walk and
// goes straight to its result. The walk reads the records over the single read port of the
// record memory. One item is in work at a time; the next item can be taken the cycle after
// the result enters the output register, and while a stalled receiver holds that register
// the new result waits and the input stays stalled. The table is emptied by its fill count,
// so there is no clearing pass after reset. A write of the kernel image end re-initialises
// the heap; o_cfg_ready is high only while no item is in work, and a pending configuration
// write holds off the request input.
`default_nettype none
`include "first_fit_heap_allocator_core_macros.svh"

module first_fit_heap_allocator_core (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        i_in_valid,
    output logic                             o_in_stall,
    input  wire logic                        i_kind,
    input  wire logic [ffha_pkg::ADDR_W-1:0] i_size,
    input  wire logic [ffha_pkg::ADDR_W-1:0] i_address,
    output logic                             o_out_valid,
    input  wire logic                        i_out_stall,
    output logic      [ffha_pkg::ADDR_W-1:0] o_address_res,
    output logic      [2:0]                  o_status,
    output logic      [ffha_pkg::ADDR_W-1:0] o_used_bytes,
    input  wire logic                        i_cfg_valid,
    output logic                             o_cfg_ready,
    input  wire logic [ffha_pkg::ADDR_W-1:0] i_cfg_data
);

    logic            w_idle, w_res_valid, w_res_take, w_in_acc, w_cfg_wr;
    ffha_pkg::t_req  w_req;
    ffha_pkg::t_res  w_res;
    logic            r_out_vld, n_out_vld;
    ffha_pkg::t_res  r_out_res;

    assign o_cfg_ready = w_idle;
    assign w_cfg_wr    = i_cfg_valid && o_cfg_ready;

    // a pending configuration write goes ahead of any request
    assign o_in_stall = !w_idle || i_cfg_valid;
    assign w_in_acc   = i_in_valid && !o_in_stall;
    assign w_req      = '{kind: i_kind, size: i_size, address: i_address};

    // result register frees up either when empty or when drained this cycle
    assign w_res_take = w_res_valid && (!r_out_vld || !i_out_stall);
    assign n_out_vld  = w_res_take || (r_out_vld && i_out_stall);

    ffha_seq u_seq (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_start      (w_in_acc),
        .i_req        (w_req),
        .i_init       (w_cfg_wr),
        .i_heap_start (ffha_pkg::heap_start(i_cfg_data)),
        .i_res_take   (w_res_take),
        .o_idle       (w_idle),
        .o_res_valid  (w_res_valid),
        .o_res        (w_res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else begin
            r_out_vld <= n_out_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_res_take) begin
            r_out_res <= w_res;
        end
    end

    assign o_out_valid   = r_out_vld;
    assign o_address_res = r_out_res.address_res;
    assign o_status      = r_out_res.status;
    assign o_used_bytes  = r_out_res.used_bytes;

    `FFHA_ASSERT_NEXT(a_busy_after_accept, w_in_acc, o_in_stall)
    `FFHA_ASSERT_NOW(a_err_no_addr, o_out_valid && (o_status != ffha_pkg::ST_OK), o_address_res == '0)
    `FFHA_ASSERT_NEXT(a_res_held, w_res_valid && r_out_vld && i_out_stall, w_res_valid)

endmodule

`default_nettype wire

>>> tb/first_fit_heap_allocator_core_tb.sv
// Self-checking testbench for the first-fit heap allocator core
`timescale 1ns / 1ps

module first_fit_heap_allocator_core_tb;

    typedef ffha_pkg::t_res t_res;

    localparam int                ADDR_W        = ffha_pkg::ADDR_W;
    localparam int                MAX_BLOCKS    = ffha_pkg::MAX_BLOCKS;
    localparam int                HEADER_BYTES  = ffha_pkg::HEADER_BYTES;
    localparam int                HEAP_LIMIT    = ffha_pkg::HEAP_LIMIT;
    localparam int                HEAP_GAP      = ffha_pkg::HEAP_GAP;
    localparam int                TAIL_PAD      = ffha_pkg::TAIL_PAD;
    localparam int                IMAGE_END_RST = ffha_pkg::IMAGE_END_RST;
    localparam logic [ADDR_W-1:0] ADDR_MAX      = ffha_pkg::ADDR_MAX;
    localparam logic              KIND_ALLOC    = ffha_pkg::KIND_ALLOC;
    localparam logic              KIND_FREE     = ffha_pkg::KIND_FREE;
    localparam logic [2:0]        ST_OK         = ffha_pkg::ST_OK;
    localparam logic [2:0]        ST_ZERO_SIZE  = ffha_pkg::ST_ZERO_SIZE;
    localparam logic [2:0]        ST_NO_MEM     = ffha_pkg::ST_NO_MEM;
    localparam logic [2:0]        ST_TABLE_FULL = ffha_pkg::ST_TABLE_FULL;
    localparam logic [2:0]        ST_NOT_FOUND  = ffha_pkg::ST_NOT_FOUND;

    localparam int    CLK_PERIOD   = 8;
    localparam int    RESET_CYCLES = 11;
    localparam int    HOLD_CYCLES  = 400;
    localparam int    DRAIN_CYCLES = 80;
    localparam int    MAX_GAP      = 200;
    localparam int    PHASES       = 6;
    localparam t_res  NO_WANT      = '0;
    localparam real   TIMEOUT_NS   = 20_000_000.0;

    logic              i_clk       = 1'b0;
    logic              i_rst_n     = 1'b0;
    logic              i_in_valid  = 1'b0;
    logic              i_kind      = KIND_ALLOC;
    logic [ADDR_W-1:0] i_size      = '0;
    logic [ADDR_W-1:0] i_address   = '0;
    logic              i_out_stall = 1'b0;
    logic              i_cfg_valid = 1'b0;
    logic [ADDR_W-1:0] i_cfg_data  = '0;
    logic              o_in_stall;
    logic              o_out_valid;
    logic [ADDR_W-1:0] o_address_res;
    logic [2:0]        o_status;
    logic [ADDR_W-1:0] o_used_bytes;
    logic              o_cfg_ready;

    first_fit_heap_allocator_core i_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (i_in_valid),
        .o_in_stall    (o_in_stall),
        .i_kind        (i_kind),
        .i_size        (i_size),
        .i_address     (i_address),
        .o_out_valid   (o_out_valid),
        .i_out_stall   (i_out_stall),
        .o_address_res (o_address_res),
        .o_status      (o_status),
        .o_used_bytes  (o_used_bytes),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_data    (i_cfg_data)
    );

    always #(CLK_PERIOD / 2.0) i_clk = ~i_clk;

    // shadow heap state
    logic [ADDR_W-1:0] rec_start [MAX_BLOCKS];
    logic [ADDR_W-1:0] rec_size  [MAX_BLOCKS];
    logic              rec_busy  [MAX_BLOCKS];
    int unsigned       rec_count;
    logic [ADDR_W-1:0] heap_top;
    logic [ADDR_W-1:0] bytes_used;

    t_res awaited_outcomes [$];
    int   fault_count    = 0;
    int   send_idle_pct  = 0;
    int   recv_stall_pct = 0;
    int   hold_asks      = 0;
    int   hold_seen      = 0;
    int   hold_left      = 0;

    typedef struct {
        logic              kind;
        logic [ADDR_W-1:0] size;
        logic [ADDR_W-1:0] address;
        bit                known;
        t_res              want;
    } t_opening_row;

    // heap base after reset is 0x101000; rows marked known carry a hand-worked result
    t_opening_row opening_rows [21] = '{
        '{KIND_ALLOC, 22'd0,      22'd0,       1'b1, '{22'd0,       ST_ZERO_SIZE, 22'd0}},
        '{KIND_ALLOC, 22'd1,      22'h3FFFFF,  1'b1, '{22'd1052680, ST_OK,        22'd13}},
        '{KIND_FREE,  22'd0,      22'd1052680, 1'b1, '{22'd0,       ST_OK,        22'd4}},
        '{KIND_FREE,  22'd0,      22'd1052680, 1'b1, '{22'd0,       ST_OK,        22'd0}},
        '{KIND_FREE,  22'd0,      22'd0,       1'b1, '{22'd0,       ST_NOT_FOUND, 22'd0}},
        '{KIND_FREE,  22'h3FFFFF, 22'h3FFFFF,  1'b1, '{22'd0,       ST_NOT_FOUND, 22'd0}},
        '{KIND_ALLOC, 22'h3FFFFF, 22'h3FFFFF,  1'b1, '{22'd0,       ST_NO_MEM,    22'd0}},
        '{KIND_ALLOC, 22'd1,      22'd0,       1'b1, '{22'd1052680, ST_OK,        22'd9}},
        '{KIND_ALLOC, 22'd100,    22'd0,       1'b0, NO_WANT},
        '{KIND_ALLOC, 22'd2,      22'd0,       1'b0, NO_WANT},
        '{KIND_FREE,  22'd0,      22'd1052693, 1'b0, NO_WANT},
        '{KIND_ALLOC, 22'd50,     22'd0,       1'b0, NO_WANT},
        '{KIND_ALLOC, 22'h2D0000, 22'd0,       1'b0, NO_WANT},
        '{KIND_ALLOC, 22'h2D0000, 22'd0,       1'b0, NO_WANT},
        '{KIND_FREE,  22'd0,      22'd1052805, 1'b0, NO_WANT},
        '{KIND_ALLOC, 22'd3,      22'd0,       1'b0, NO_WANT},
        '{KIND_FREE,  22'd0,      22'd1052681, 1'b0, NO_WANT},
        '{KIND_ALLOC, 22'd61266,  22'd0,       1'b0, NO_WANT},
        '{KIND_ALLOC, 22'd61265,  22'd0,       1'b0, NO_WANT},
        '{KIND_ALLOC, 22'd1,      22'd0,       1'b0, NO_WANT},
        '{KIND_ALLOC, 22'd5,      22'd0,       1'b0, NO_WANT}
    };

    int phase_items [PHASES] = '{300, 100, 350, 250, 300, 229};
    int phase_send  [PHASES] = '{0,   79,  0,   15,  79,  0};
    int phase_recv  [PHASES] = '{0,   0,   79,  15,  0,   79};

    function automatic void heap_reinit(input logic [ADDR_W-1:0] kend);
        int unsigned base;
        base = 32'(kend) + HEAP_GAP;
        if (base > HEAP_LIMIT)
            base = HEAP_LIMIT;
        for (int i = 0; i < MAX_BLOCKS; i++)
            rec_busy[i] = 1'b0;
        rec_count  = 0;
        heap_top   = ADDR_W'(base);
        bytes_used = '0;
    endfunction

    function automatic void charge_bytes(input longint unsigned n);
        longint unsigned sum;
        sum = longint'(bytes_used) + n;
        bytes_used = (sum > longint'(ADDR_MAX)) ? ADDR_MAX : ADDR_W'(sum);
    endfunction

    function automatic t_res heap_outcome(input logic kind, input logic [ADDR_W-1:0] size,
                                          input logic [ADDR_W-1:0] addr);
        t_res            r;
        bit              hit;
        longint unsigned span_end;
        longint unsigned drop;
        r   = '0;
        hit = 1'b0;
        if (kind == KIND_ALLOC) begin
            if (size == '0) begin
                r.status = ST_ZERO_SIZE;
            end else begin
                // first free record big enough, taken whole
                for (int i = 0; i < int'(rec_count); i++) begin
                    if (!hit && !rec_busy[i] && rec_size[i] >= size) begin
                        rec_busy[i]   = 1'b1;
                        charge_bytes(longint'(size) + HEADER_BYTES);
                        r.address_res = ADDR_W'(32'(rec_start[i]) + HEADER_BYTES);
                        hit = 1'b1;
                    end
                end
                if (!hit) begin
                    span_end = longint'(heap_top) + longint'(size) + HEADER_BYTES;
                    if (span_end >= HEAP_LIMIT) begin
                        r.status = ST_NO_MEM;
                    end else if (rec_count >= MAX_BLOCKS) begin
                        r.status = ST_TABLE_FULL;
                    end else begin
                        rec_start[rec_count] = heap_top;
                        rec_size[rec_count]  = size;
                        rec_busy[rec_count]  = 1'b1;
                        rec_count++;
                        r.address_res = ADDR_W'(32'(heap_top) + HEADER_BYTES);
                        heap_top      = ADDR_W'(span_end + TAIL_PAD);
                        charge_bytes(longint'(size) + HEADER_BYTES + TAIL_PAD);
                    end
                end
            end
        end else begin
            for (int i = 0; i < int'(rec_count); i++) begin
                if (!hit && 32'(rec_start[i]) + HEADER_BYTES == 32'(addr)) begin
                    // drops even for an already free record, floored at zero
                    drop = longint'(rec_size[i]) + HEADER_BYTES;
                    bytes_used  = (drop >= longint'(bytes_used)) ? '0
                                : ADDR_W'(longint'(bytes_used) - drop);
                    rec_busy[i] = 1'b0;
                    hit = 1'b1;
                end
            end
            if (!hit)
                r.status = ST_NOT_FOUND;
        end
        r.used_bytes = bytes_used;
        return r;
    endfunction

    function automatic logic [ADDR_W-1:0] draw_size();
        int pick;
        pick = $urandom_range(0, 99);
        if (pick < 60)
            return ADDR_W'($urandom_range(1, 64));
        else if (pick < 90)
            return ADDR_W'($urandom_range(1, 4096));
        else
            return ADDR_W'($urandom_range(1, 32'h40000));
    endfunction

    // mostly allocations and frees of known records, with some noise mixed in
    task automatic draw_request(output logic kind, output logic [ADDR_W-1:0] size,
                                output logic [ADDR_W-1:0] addr);
        int pick;
        int idx;
        pick = $urandom_range(0, 99);
        kind = KIND_ALLOC;
        size = ADDR_W'($urandom());
        addr = ADDR_W'($urandom());
        idx  = (rec_count != 0) ? int'($urandom_range(0, rec_count - 1)) : 0;
        if (pick < 38) begin
            size = draw_size();
        end else if (pick < 70 && rec_count != 0) begin
            kind = KIND_FREE;
            addr = ADDR_W'(32'(rec_start[idx]) + HEADER_BYTES);
        end else if (pick < 76 && rec_count != 0) begin
            size = rec_size[idx];
        end else if (pick < 80) begin
            size = '0;
        end else if (pick < 88) begin
            kind = KIND_FREE;
        end else if (pick < 92 && rec_count != 0) begin
            kind = KIND_FREE;
            addr = ADDR_W'(32'(rec_start[idx]) + HEADER_BYTES
                           + $urandom_range(1, 4) - ($urandom_range(0, 1) * 5));
        end else if (pick < 92) begin
            kind = KIND_FREE;
        end
        // remaining picks keep a full-range size
    endtask

    task automatic offer_request(input logic kind, input logic [ADDR_W-1:0] size,
                                 input logic [ADDR_W-1:0] addr, input bit known,
                                 input t_res want);
        t_res predicted;
        int   gap;
        i_in_valid <= 1'b1;
        i_kind     <= kind;
        i_size     <= size;
        i_address  <= addr;
        do @(posedge i_clk); while (o_in_stall);
        predicted = heap_outcome(kind, size, addr);
        awaited_outcomes.push_back(known ? want : predicted);
        gap = 0;
        while (gap < MAX_GAP && $urandom_range(0, 99) < send_idle_pct)
            gap++;
        if (gap != 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    always @(posedge i_clk) begin
        t_res want;
        if (o_out_valid && !i_out_stall) begin
            if (awaited_outcomes.size() == 0) begin
                $error("result item with nothing expected");
                fault_count++;
            end else begin
                want = awaited_outcomes.pop_front();
                if (o_address_res !== want.address_res) begin
                    $error("address_res: expected %0d, got %0d", want.address_res,
                           o_address_res);
                    fault_count++;
                end
                if (o_status !== want.status) begin
                    $error("status: expected %0d, got %0d", want.status, o_status);
                    fault_count++;
                end
                if (o_used_bytes !== want.used_bytes) begin
                    $error("used_bytes: expected %0d, got %0d", want.used_bytes,
                           o_used_bytes);
                    fault_count++;
                end
            end
        end
        // a long hold-off lets the core fill and push back on its input
        if (hold_left != 0) begin
            hold_left   <= hold_left - 1;
            i_out_stall <= 1'b1;
        end else if (hold_asks != hold_seen) begin
            hold_seen   <= hold_asks;
            hold_left   <= HOLD_CYCLES;
            i_out_stall <= 1'b1;
        end else begin
            i_out_stall <= ($urandom_range(0, 99) < recv_stall_pct);
        end
    end

    initial begin
        logic              kind;
        logic [ADDR_W-1:0] size;
        logic [ADDR_W-1:0] addr;
        int unsigned       kend;
        heap_reinit(ADDR_W'(IMAGE_END_RST));
        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;

        foreach (opening_rows[r])
            offer_request(opening_rows[r].kind, opening_rows[r].size, opening_rows[r].address,
                          opening_rows[r].known, opening_rows[r].want);
        i_in_valid <= 1'b0;

        for (int p = 0; p < PHASES; p++) begin
            while (awaited_outcomes.size() != 0) @(posedge i_clk);
            case (p)
                0:       kend = 0;
                1:       kend = HEAP_LIMIT - 1;
                2:       kend = $urandom_range(0, IMAGE_END_RST);
                3:       kend = HEAP_LIMIT - HEAP_GAP - 3000;
                4:       kend = IMAGE_END_RST;
                default: kend = $urandom_range(0, HEAP_LIMIT - 1);
            endcase
            i_cfg_valid <= 1'b1;
            i_cfg_data  <= ADDR_W'(kend);
            do @(posedge i_clk); while (!o_cfg_ready);
            heap_reinit(ADDR_W'(kend));
            i_cfg_valid <= 1'b0;

            send_idle_pct  = phase_send[p];
            recv_stall_pct = phase_recv[p];
            if (p == 0)
                hold_asks++;
            for (int k = 0; k < phase_items[p]; k++) begin
                draw_request(kind, size, addr);
                offer_request(kind, size, addr, 1'b0, NO_WANT);
            end
            i_in_valid <= 1'b0;
        end

        while (awaited_outcomes.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (fault_count == 0)
            $display("PASSED: all results match");
        else
            $display("FAILED: results differ");
        $finish;
    end

    initial begin
        #(TIMEOUT_NS);
        $display("FAILED: results differ");
        $finish;
    end

endmodule

>>> filelist.f
+incdir+design
design/ffha_pkg.sv
design/ffha_ram.sv
design/ffha_seq.sv
design/first_fit_heap_allocator_core.sv
tb/first_fit_heap_allocator_core_tb.sv
